// ----- src/bpa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, codes and helpers shared by the buddy page allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int POOL_W = 13;
    localparam int PAGE_W = 12;
    localparam int RANK_W = 5;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int TAG_W  = 6;
    localparam int SZ_W   = 17;
    localparam int UOP_W  = 5;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_INVAL = 2'd1;
    localparam logic [ST_W-1:0] ST_NOSPC = 2'd2;

    // micro-operation codes, also the controller state codes
    localparam logic [UOP_W-1:0] U_INIT   = 5'd0;
    localparam logic [UOP_W-1:0] U_TOP    = 5'd1;
    localparam logic [UOP_W-1:0] U_CLR    = 5'd2;
    localparam logic [UOP_W-1:0] U_CARVE  = 5'd3;
    localparam logic [UOP_W-1:0] U_IDLE   = 5'd4;
    localparam logic [UOP_W-1:0] U_PUSHA  = 5'd5;
    localparam logic [UOP_W-1:0] U_PUSHB  = 5'd6;
    localparam logic [UOP_W-1:0] U_ULA    = 5'd7;
    localparam logic [UOP_W-1:0] U_ULB    = 5'd8;
    localparam logic [UOP_W-1:0] U_ACHK   = 5'd9;
    localparam logic [UOP_W-1:0] U_ASCAN  = 5'd10;
    localparam logic [UOP_W-1:0] U_ASPLIT = 5'd11;
    localparam logic [UOP_W-1:0] U_FCHK   = 5'd12;
    localparam logic [UOP_W-1:0] U_FTAG   = 5'd13;
    localparam logic [UOP_W-1:0] U_FLOOP  = 5'd14;
    localparam logic [UOP_W-1:0] U_FBTAG  = 5'd15;
    localparam logic [UOP_W-1:0] U_FMERGE = 5'd16;
    localparam logic [UOP_W-1:0] U_FEND   = 5'd17;
    localparam logic [UOP_W-1:0] U_QCHK   = 5'd18;
    localparam logic [UOP_W-1:0] U_QTAG   = 5'd19;
    localparam logic [UOP_W-1:0] U_QRD    = 5'd20;
    localparam logic [UOP_W-1:0] U_QCMP   = 5'd21;
    localparam logic [UOP_W-1:0] U_CRUN   = 5'd22;
    localparam logic [UOP_W-1:0] U_DONE   = 5'd23;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [RANK_W-1:0] rank;
        logic [PAGE_W-1:0] page;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [PAGE_W-1:0] alloc_page;
        logic [POOL_W-1:0] value;
    } out_item_t;

    typedef struct packed {
        logic [UOP_W-1:0] uop;
        logic             st_load;
        logic [ST_W-1:0]  st_code;
    } cmd_t;

    typedef struct packed {
        logic            cfg_go;
        logic            in_fire;
        logic [OP_W-1:0] op;
        logic            top_more;
        logic            clr_last;
        logic            r_zero;
        logic            fit;
        logic            rank_bad;
        logic            rank_above;
        logic            c_over;
        logic            head_nil;
        logic            split_more;
        logic            pg_out;
        logic            tag_pos;
        logic            tag_zero;
        logic            r_lt_top;
        logic            b_out;
        logic            tag_match;
        logic            out_free;
    } sts_t;

    function automatic logic [SZ_W-1:0] size_of_rank(input logic [RANK_W-1:0] r);
        logic [RANK_W-1:0] sh;
        sh = r - RANK_W'(1);
        return SZ_W'(1) << sh;
    endfunction

    function automatic logic [TAG_W-1:0] neg_tag(input logic [RANK_W-1:0] r);
        return TAG_W'(0) - TAG_W'(r);
    endfunction

endpackage
`default_nettype wire

// ----- src/buddy_page_allocator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy allocator over a pool of page indices with allocate, free, rank query and count ops.
// ----------------------------------------------------------------------------
// After reset, and after every nonzero write of the pool size, the block
// rebuilds its free lists: it finds the top rank, clears the page tag
// memory and then carves the pool into free blocks; no item is accepted
// meanwhile. Items are then handled one at a time by a sequencer over
// one-write, one-read tag and link memories. A rank query probes ranks
// from the top down; an allocate scans ranks upward, unlinks a block and
// splits it; a free merges with free buddies rank by rank. The result is
// held in an output register, so the next item can be accepted while it
// waits.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top #(
    parameter int MAX_PAGES  = 4096,
    parameter int RANK_LIMIT = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpa_pkg::POOL_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bpa_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bpa_pkg::out_item_t            out_item
);
    import bpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;
    assign in_ready  = (cmd.uop == U_IDLE);

    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bpa_datapath #(.MAX_PAGES(MAX_PAGES), .RANK_LIMIT(RANK_LIMIT)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.status != 2'd3))
        else $error("undefined status code");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status != ST_OK))
            |-> (out_item.alloc_page == '0) && (out_item.value == '0))
        else $error("failed item carries data");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_data != '0)) |=> !in_ready)
        else $error("item accepted during rebuild");

endmodule
`default_nettype wire

// ----- src/bpa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/bpa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: steps the datapath through initialisation and each request.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  bpa_pkg::sts_t sts,
    output bpa_pkg::cmd_t cmd
);
    import bpa_pkg::*;

    logic [UOP_W-1:0] state_reg, state_next;
    logic [UOP_W-1:0] ret_reg, ret_next;
    logic             st_load;
    logic [ST_W-1:0]  st_code;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        st_load    = 1'b0;
        st_code    = ST_OK;
        case (state_reg)
            U_INIT:  state_next = U_TOP;
            U_TOP:   if (!sts.top_more) state_next = U_CLR;
            U_CLR:   if (sts.clr_last) state_next = U_CARVE;
            U_CARVE:
            begin
                if (sts.r_zero)
                begin
                    state_next = U_IDLE;
                end
                else if (sts.fit)
                begin
                    state_next = U_PUSHA;
                    ret_next   = U_CARVE;
                end
            end
            U_PUSHA: state_next = U_PUSHB;
            U_PUSHB: state_next = ret_reg;
            U_ULA:   state_next = U_ULB;
            U_ULB:   state_next = ret_reg;
            U_IDLE:
            begin
                if (sts.in_fire)
                begin
                    case (sts.op)
                        OP_ALLOC: state_next = U_ACHK;
                        OP_FREE:  state_next = U_FCHK;
                        OP_QUERY: state_next = U_QCHK;
                        default:  state_next = U_CRUN;
                    endcase
                end
            end
            U_ACHK:
            begin
                if (sts.rank_bad || sts.rank_above)
                begin
                    st_load    = 1'b1;
                    st_code    = sts.rank_bad ? ST_INVAL : ST_NOSPC;
                    state_next = U_DONE;
                end
                else
                begin
                    state_next = U_ASCAN;
                end
            end
            U_ASCAN:
            begin
                if (sts.c_over)
                begin
                    st_load    = 1'b1;
                    st_code    = ST_NOSPC;
                    state_next = U_DONE;
                end
                else if (!sts.head_nil)
                begin
                    state_next = U_ULA;
                    ret_next   = U_ASPLIT;
                end
            end
            U_ASPLIT:
            begin
                if (sts.split_more)
                begin
                    state_next = U_PUSHA;
                    ret_next   = U_ASPLIT;
                end
                else
                begin
                    state_next = U_DONE;
                end
            end
            U_FCHK, U_QCHK:
            begin
                if (sts.pg_out)
                begin
                    st_load    = 1'b1;
                    st_code    = ST_INVAL;
                    state_next = U_DONE;
                end
                else
                begin
                    state_next = (state_reg == U_FCHK) ? U_FTAG : U_QTAG;
                end
            end
            U_FTAG:
            begin
                if (!sts.tag_pos)
                begin
                    st_load    = 1'b1;
                    st_code    = ST_INVAL;
                    state_next = U_DONE;
                end
                else
                begin
                    state_next = U_FLOOP;
                end
            end
            U_FLOOP: state_next = (!sts.r_lt_top || sts.b_out) ? U_FEND : U_FBTAG;
            U_FBTAG:
            begin
                if (sts.tag_match)
                begin
                    state_next = U_ULA;
                    ret_next   = U_FMERGE;
                end
                else
                begin
                    state_next = U_FEND;
                end
            end
            U_FMERGE: state_next = U_FLOOP;
            U_FEND:
            begin
                state_next = U_PUSHA;
                ret_next   = U_DONE;
            end
            U_QTAG:  state_next = sts.tag_zero ? U_QRD : U_DONE;
            U_QRD:
            begin
                if (sts.r_zero)
                begin
                    st_load    = 1'b1;
                    st_code    = ST_INVAL;
                    state_next = U_DONE;
                end
                else
                begin
                    state_next = U_QCMP;
                end
            end
            U_QCMP:  state_next = sts.tag_match ? U_DONE : U_QRD;
            U_CRUN:
            begin
                st_load    = sts.rank_bad;
                st_code    = ST_INVAL;
                state_next = U_DONE;
            end
            U_DONE:  if (sts.out_free) state_next = U_IDLE;
            default: state_next = U_INIT;
        endcase
        if (sts.cfg_go)
        begin
            state_next = U_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_INIT;
            ret_reg   <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign cmd.uop     = state_reg;
    assign cmd.st_load = st_load;
    assign cmd.st_code = st_code;

endmodule
`default_nettype wire

// ----- src/bpa_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_datapath
// Page tag and free list memories, list heads, counters and result register.
// ----------------------------------------------------------------------------
module bpa_datapath #(
    parameter int MAX_PAGES  = 4096,
    parameter int RANK_LIMIT = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::cmd_t                 cmd,
    output bpa_pkg::sts_t                 sts,
    input  logic                          cfg_valid,
    input  logic [bpa_pkg::POOL_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  bpa_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bpa_pkg::out_item_t            out_item
);
    import bpa_pkg::*;

    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int LW  = PW + 1;
    localparam int RIW = $clog2(RANK_LIMIT + 1);
    localparam logic [LW-1:0] NIL = '1;
    localparam logic [RANK_W-1:0] RL = RANK_W'(RANK_LIMIT);
    localparam logic [SZ_W-1:0] MAXP = SZ_W'(MAX_PAGES);
    localparam logic [POOL_W-1:0] POOL_RST =
        (MAX_PAGES < 4096) ? POOL_W'(MAX_PAGES) : POOL_W'(4096);

    in_item_t          in_reg, in_next;
    logic [POOL_W-1:0] pool_reg, pool_next;
    logic [RANK_W-1:0] top_reg, top_next;
    logic [PW-1:0]     clr_reg, clr_next;
    logic [RANK_W-1:0] r_reg, r_next;
    logic [RANK_W-1:0] c_reg, c_next;
    logic [PW-1:0]     p_reg, p_next;
    logic [PW-1:0]     b_reg, b_next;
    logic [POOL_W-1:0] left_reg, left_next;
    logic [RANK_W-1:0] push_r_reg, push_r_next;
    logic [PW-1:0]     push_pg_reg, push_pg_next;
    logic [RANK_W-1:0] ul_r_reg, ul_r_next;
    logic [PW-1:0]     ul_pg_reg, ul_pg_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [PAGE_W-1:0] apage_reg, apage_next;
    logic [POOL_W-1:0] val_reg, val_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [LW-1:0]     head_reg [1:RANK_LIMIT];
    logic [LW-1:0]     head_next [1:RANK_LIMIT];
    logic [POOL_W-1:0] cnt_reg [1:RANK_LIMIT];
    logic [POOL_W-1:0] cnt_next [1:RANK_LIMIT];

    logic              t_we, n_we, p_we;
    logic [PW-1:0]     t_wa, n_wa, p_wa, t_ra, l_ra;
    logic [TAG_W-1:0]  t_wd, tag_rd;
    logic [LW-1:0]     n_wd, p_wd, next_rd, prev_rd;

    logic              in_fire;
    logic [PW-1:0]     pg_a, b_calc, q_addr;
    logic [SZ_W-1:0]   sz_r, sz_c1, sz_t1;
    logic [LW-1:0]     head_c, head_p;

    assign in_fire = in_valid && (cmd.uop == U_IDLE);
    assign pg_a    = PW'(in_reg.page);
    assign sz_r    = size_of_rank(r_reg);
    assign sz_c1   = size_of_rank(c_reg - RANK_W'(1));
    assign sz_t1   = size_of_rank(top_reg + RANK_W'(1));
    assign b_calc  = p_reg ^ sz_r[PW-1:0];
    assign q_addr  = pg_a & ~(sz_r[PW-1:0] - PW'(1));
    assign head_c  = head_reg[c_reg[RIW-1:0]];
    assign head_p  = head_reg[push_r_reg[RIW-1:0]];

    assign sts.cfg_go     = cfg_valid && (cfg_data != '0);
    assign sts.in_fire    = in_fire;
    assign sts.op         = in_item.op;
    assign sts.top_more   = (top_reg < RL) && (sz_t1 <= SZ_W'(pool_reg));
    assign sts.clr_last   = (SZ_W'(clr_reg) == MAXP - SZ_W'(1));
    assign sts.r_zero     = (r_reg == '0);
    assign sts.fit        = (SZ_W'(left_reg) >= sz_r);
    assign sts.rank_bad   = (in_reg.rank == '0) || (in_reg.rank > RL);
    assign sts.rank_above = (in_reg.rank > top_reg);
    assign sts.c_over     = (c_reg > top_reg);
    assign sts.head_nil   = (head_c == NIL);
    assign sts.split_more = (c_reg > in_reg.rank);
    assign sts.pg_out     = (SZ_W'(in_reg.page) >= SZ_W'(pool_reg));
    assign sts.tag_pos    = !tag_rd[TAG_W-1] && (tag_rd != '0);
    assign sts.tag_zero   = (tag_rd == '0);
    assign sts.r_lt_top   = (r_reg < top_reg);
    assign sts.b_out      = (SZ_W'(b_calc) >= SZ_W'(pool_reg));
    assign sts.tag_match  = (tag_rd == neg_tag(r_reg));
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        in_next      = in_reg;
        pool_next    = pool_reg;
        top_next     = top_reg;
        clr_next     = clr_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        p_next       = p_reg;
        b_next       = b_reg;
        left_next    = left_reg;
        push_r_next  = push_r_reg;
        push_pg_next = push_pg_reg;
        ul_r_next    = ul_r_reg;
        ul_pg_next   = ul_pg_reg;
        st_next      = cmd.st_load ? cmd.st_code : st_reg;
        apage_next   = apage_reg;
        val_next     = val_reg;
        out_next     = out_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
        n_we = 1'b0; n_wa = '0; n_wd = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; l_ra = '0;
        out_valid_next = out_valid_reg && !out_ready;

        case (cmd.uop)
            U_INIT:
            begin
                top_next = RANK_W'(1);
                clr_next = '0;
                for (int i = 1; i <= RANK_LIMIT; i++)
                begin
                    head_next[i] = NIL;
                    cnt_next[i]  = '0;
                end
            end
            U_TOP:
            begin
                if (sts.top_more)
                begin
                    top_next = top_reg + RANK_W'(1);
                end
            end
            U_CLR:
            begin
                t_we     = 1'b1;
                t_wa     = clr_reg;
                clr_next = clr_reg + PW'(1);
                if (sts.clr_last)
                begin
                    r_next    = top_reg;
                    p_next    = '0;
                    left_next = pool_reg;
                end
            end
            U_CARVE:
            begin
                if (!sts.r_zero)
                begin
                    if (sts.fit)
                    begin
                        push_r_next  = r_reg;
                        push_pg_next = p_reg;
                        p_next       = p_reg + sz_r[PW-1:0];
                        left_next    = left_reg - sz_r[POOL_W-1:0];
                    end
                    else
                    begin
                        r_next = r_reg - RANK_W'(1);
                    end
                end
            end
            U_PUSHA:
            begin
                n_we = 1'b1;
                n_wa = push_pg_reg;
                n_wd = head_p;
                if (head_p != NIL)
                begin
                    p_we = 1'b1;
                    p_wa = head_p[PW-1:0];
                    p_wd = {1'b0, push_pg_reg};
                end
                t_we = 1'b1;
                t_wa = push_pg_reg;
                t_wd = neg_tag(push_r_reg);
                head_next[push_r_reg[RIW-1:0]] = {1'b0, push_pg_reg};
                cnt_next[push_r_reg[RIW-1:0]]  = cnt_reg[push_r_reg[RIW-1:0]] + POOL_W'(1);
            end
            U_PUSHB:
            begin
                p_we = 1'b1;
                p_wa = push_pg_reg;
                p_wd = NIL;
            end
            U_ULA:
            begin
                l_ra = ul_pg_reg;
            end
            U_ULB:
            begin
                if (prev_rd != NIL)
                begin
                    n_we = 1'b1;
                    n_wa = prev_rd[PW-1:0];
                    n_wd = next_rd;
                end
                else
                begin
                    head_next[ul_r_reg[RIW-1:0]] = next_rd;
                end
                if (next_rd != NIL)
                begin
                    p_we = 1'b1;
                    p_wa = next_rd[PW-1:0];
                    p_wd = prev_rd;
                end
                t_we = 1'b1;
                t_wa = ul_pg_reg;
                cnt_next[ul_r_reg[RIW-1:0]] = cnt_reg[ul_r_reg[RIW-1:0]] - POOL_W'(1);
            end
            U_IDLE:
            begin
                if (in_fire)
                begin
                    in_next    = in_item;
                    st_next    = ST_OK;
                    apage_next = '0;
                    val_next   = '0;
                end
            end
            U_ACHK:
            begin
                c_next = in_reg.rank;
            end
            U_ASCAN:
            begin
                if (!sts.c_over)
                begin
                    if (!sts.head_nil)
                    begin
                        p_next     = head_c[PW-1:0];
                        ul_r_next  = c_reg;
                        ul_pg_next = head_c[PW-1:0];
                    end
                    else
                    begin
                        c_next = c_reg + RANK_W'(1);
                    end
                end
            end
            U_ASPLIT:
            begin
                if (sts.split_more)
                begin
                    c_next       = c_reg - RANK_W'(1);
                    push_r_next  = c_reg - RANK_W'(1);
                    push_pg_next = p_reg + sz_c1[PW-1:0];
                end
                else
                begin
                    t_we       = 1'b1;
                    t_wa       = p_reg;
                    t_wd       = TAG_W'(in_reg.rank);
                    apage_next = PAGE_W'(p_reg);
                end
            end
            U_FCHK, U_QCHK:
            begin
                t_ra = pg_a;
            end
            U_FTAG:
            begin
                if (sts.tag_pos)
                begin
                    r_next = tag_rd[RANK_W-1:0];
                    p_next = pg_a;
                    t_we   = 1'b1;
                    t_wa   = pg_a;
                end
            end
            U_FLOOP:
            begin
                b_next = b_calc;
                t_ra   = b_calc;
            end
            U_FBTAG:
            begin
                ul_r_next  = r_reg;
                ul_pg_next = b_reg;
            end
            U_FMERGE:
            begin
                if (b_reg < p_reg)
                begin
                    p_next = b_reg;
                end
                r_next = r_reg + RANK_W'(1);
            end
            U_FEND:
            begin
                push_r_next  = r_reg;
                push_pg_next = p_reg;
            end
            U_QTAG:
            begin
                if (sts.tag_pos)
                begin
                    val_next = POOL_W'(tag_rd[RANK_W-1:0]);
                end
                else if (!sts.tag_zero)
                begin
                    val_next = POOL_W'(RANK_W'(TAG_W'(0) - tag_rd));
                end
                else
                begin
                    r_next = top_reg;
                end
            end
            U_QRD:
            begin
                t_ra = q_addr;
            end
            U_QCMP:
            begin
                if (sts.tag_match)
                begin
                    val_next = POOL_W'(r_reg);
                end
                else
                begin
                    r_next = r_reg - RANK_W'(1);
                end
            end
            U_CRUN:
            begin
                if (!sts.rank_bad)
                begin
                    val_next = cnt_reg[in_reg.rank[RIW-1:0]];
                end
            end
            U_DONE:
            begin
                if (sts.out_free)
                begin
                    out_next.status     = st_reg;
                    out_next.alloc_page = apage_reg;
                    out_next.value      = val_reg;
                    out_valid_next      = 1'b1;
                end
            end
            default: ;
        endcase

        if (sts.cfg_go)
        begin
            pool_next = (SZ_W'(cfg_data) > MAXP) ? POOL_W'(MAX_PAGES) : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg      <= POOL_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pool_reg      <= pool_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        top_reg     <= top_next;
        clr_reg     <= clr_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        p_reg       <= p_next;
        b_reg       <= b_next;
        left_reg    <= left_next;
        push_r_reg  <= push_r_next;
        push_pg_reg <= push_pg_next;
        ul_r_reg    <= ul_r_next;
        ul_pg_reg   <= ul_pg_next;
        st_reg      <= st_next;
        apage_reg   <= apage_next;
        val_reg     <= val_next;
        out_reg     <= out_next;
        head_reg    <= head_next;
        cnt_reg     <= cnt_next;
    end

    bpa_ram #(.WIDTH(TAG_W), .DEPTH(MAX_PAGES)) u_tag_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_wa),
        .wdata (t_wd),
        .raddr (t_ra),
        .rdata (tag_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES)) u_next_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_wa),
        .wdata (n_wd),
        .raddr (l_ra),
        .rdata (next_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES)) u_prev_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_wa),
        .wdata (p_wd),
        .raddr (l_ra),
        .rdata (prev_rd)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
`default_nettype wire
